@@ rtl/tpdre_pkg.sv @@
// Shared constants, register indexes and controller/datapath interface types
// for the three-phase delay/ramp envelope. No dependencies.
package tpdre_pkg;

	// fixed-point format and field widths
	localparam int FRAC_BITS     = 16;
	localparam int DURATION_BITS = 16;
	localparam int NUM_REGS      = 6;
	localparam int IDX_W         = $clog2(NUM_REGS);
	localparam int ADDR_W        = IDX_W + 2;
	localparam int DATA_W        = 32;
	localparam int POS_W         = FRAC_BITS + 2;   // stored position, 0..3
	localparam int SUM_W         = POS_W + 1;       // position plus one step
	localparam int CRED_W        = FRAC_BITS + 1;   // credit and step, 0..1
	localparam int RATIO_W       = FRAC_BITS + 1;
	localparam int OVS_W         = FRAC_BITS;       // overshoot stays below one step
	localparam int PROD_W        = OVS_W + DURATION_BITS;
	localparam int NUM_W         = ((CRED_W > DURATION_BITS) ? CRED_W : DURATION_BITS) + 1;
	localparam int DIV_STEPS     = NUM_W;
	localparam int CNT_W         = $clog2(DIV_STEPS + 1);
	localparam int IN_W          = 8;
	localparam int OUT_W         = ((RATIO_W + 7) / 8) * 8;

	localparam logic [SUM_W-1:0] ONE_Q = SUM_W'(1) << FRAC_BITS;
	localparam logic [SUM_W-1:0] END_Q = SUM_W'(3) << FRAC_BITS;

	// register indexes
	localparam logic [IDX_W-1:0] REG_PRE_FWD  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_RAMP_FWD = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_POST_FWD = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_PRE_REV  = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_RAMP_REV = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_POST_REV = IDX_W'(5);

	// input tdata bit positions
	localparam int BIT_REVERSE = 0;
	localparam int BIT_PREVIEW = 1;
	localparam int BIT_ENABLED = 2;

	typedef logic [NUM_REGS-1:0][DURATION_BITS-1:0] lens_t;

	// commands from controller to datapath
	typedef struct packed {
		logic init;       // latch flags, load mirrored position, credit = 1
		logic adv;        // segment already passed: next segment
		logic skip;       // zero-length segment: jump to its end
		logic clamp;      // disabled tick: clamp to segment start, stop
		logic div_start;  // load divider with credit + d - 1
		logic div_step;   // one restoring divide step
		logic add;        // add step, keep overshoot if past the end
		logic mul;        // credit = min(overshoot * d, 1), next segment
		logic load;       // write result register, store position if enabled and preview
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic prv;
		logic en;
		logic k_done;
		logic pos_ge_hi;
		logic len_zero;
		logic div_last;
		logic sum_le_hi;
	} stat_t;

endpackage

@@ rtl/tpdre_cfg.sv @@
// APB register file holding the six segment lengths.
// Depends on tpdre_pkg.
module tpdre_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpdre_pkg::ADDR_W-1:0]  paddr,
	input  logic [tpdre_pkg::DATA_W-1:0]  pwdata,
	output logic [tpdre_pkg::DATA_W-1:0]  prdata,
	output tpdre_pkg::lens_t              lens
);
	import tpdre_pkg::*;

	logic [IDX_W-1:0] idx;
	logic             wr_en;
	lens_t            lens_q;

	assign idx   = paddr[ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;

	// register writes, out-of-range indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens_q <= '0;
		end else if (wr_en && (idx < IDX_W'(NUM_REGS))) begin
			lens_q[idx] <= pwdata[DURATION_BITS-1:0];
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		if (idx < IDX_W'(NUM_REGS)) begin
			prdata = DATA_W'(lens_q[idx]);
		end
	end

	assign lens = lens_q;

endmodule

@@ rtl/tpdre_dp.sv @@
// Datapath: position/credit registers, shared restoring divider,
// overshoot multiplier and the output ratio register. Depends on tpdre_pkg.
module tpdre_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [tpdre_pkg::IN_W-1:0]     in_data,
	input  tpdre_pkg::lens_t               lens,
	input  tpdre_pkg::cmd_t                cmd,
	output tpdre_pkg::stat_t               stat,
	output logic [tpdre_pkg::RATIO_W-1:0]  ratio
);
	import tpdre_pkg::*;

	logic                     rev_q, prv_q, en_q;
	logic [POS_W-1:0]         position_q;
	logic [SUM_W-1:0]         pos_q;
	logic [CRED_W-1:0]        cred_q;
	logic [1:0]               k_q;
	logic [OVS_W-1:0]         ovs_q;
	logic [NUM_W-1:0]         num_q;
	logic [DURATION_BITS-1:0] rem_q;
	logic [NUM_W-1:0]         quo_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [RATIO_W-1:0]       ratio_q;

	logic [DURATION_BITS-1:0] d_sel;
	logic [SUM_W-1:0]         lo, hi, sum, start_pos, fin_pos, diff;
	logic [DURATION_BITS:0]   trial;
	logic                     trial_ge;
	logic [PROD_W-1:0]        prod;
	logic [RATIO_W-1:0]       ratio_calc;
	logic                     in_rev;

	// length of segment k for the current direction
	function automatic logic [DURATION_BITS-1:0] seg_len(lens_t l, logic r, logic [1:0] k);
		logic [IDX_W-1:0] idx;
		idx = r ? (IDX_W'(k) + REG_PRE_REV) : IDX_W'(k);
		seg_len = '0;
		if (idx < IDX_W'(NUM_REGS)) begin
			seg_len = l[idx];
		end
	endfunction

	assign d_sel = seg_len(lens, rev_q, k_q);
	assign lo    = {1'b0, k_q, {FRAC_BITS{1'b0}}};
	assign hi    = {3'(k_q) + 3'd1, {FRAC_BITS{1'b0}}};
	assign sum   = pos_q + SUM_W'(quo_q[CRED_W-1:0]);

	// clamp stored position to 3, mirror for reverse
	assign in_rev = in_data[BIT_REVERSE];
	always_comb begin
		start_pos = SUM_W'(position_q);
		if (start_pos > END_Q) begin
			start_pos = END_Q;
		end
		if (in_rev) begin
			start_pos = END_Q - start_pos;
		end
	end

	// divider trial subtract
	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign trial_ge = trial >= {1'b0, d_sel};

	// overshoot times segment length
	assign prod = PROD_W'(ovs_q) * PROD_W'(d_sel);

	// final position and clamped ratio
	assign fin_pos = rev_q ? (END_Q - pos_q) : pos_q;
	assign diff    = fin_pos - ONE_Q;
	always_comb begin
		if (!prv_q) begin
			ratio_calc = rev_q ? '0 : RATIO_W'(ONE_Q);
		end else if (fin_pos <= ONE_Q) begin
			ratio_calc = '0;
		end else if (diff >= ONE_Q) begin
			ratio_calc = RATIO_W'(ONE_Q);
		end else begin
			ratio_calc = diff[RATIO_W-1:0];
		end
	end

	// persistent position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
		end else if (cmd.load && en_q && prv_q) begin
			position_q <= fin_pos[POS_W-1:0];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			rev_q  <= in_data[BIT_REVERSE];
			prv_q  <= in_data[BIT_PREVIEW];
			en_q   <= in_data[BIT_ENABLED];
			pos_q  <= start_pos;
			cred_q <= CRED_W'(ONE_Q);
			k_q    <= 2'd0;
		end
		if (cmd.adv) begin
			k_q <= k_q + 2'd1;
		end
		if (cmd.skip) begin
			pos_q <= hi;
			k_q   <= k_q + 2'd1;
		end
		if (cmd.clamp && (pos_q < lo)) begin
			pos_q <= lo;
		end
		if (cmd.add) begin
			if (sum <= hi) begin
				pos_q <= (sum < lo) ? lo : sum;
			end else begin
				ovs_q <= OVS_W'(sum - hi);
				pos_q <= hi;
			end
		end
		if (cmd.mul) begin
			cred_q <= (prod > PROD_W'(ONE_Q)) ? CRED_W'(ONE_Q) : prod[CRED_W-1:0];
			k_q    <= k_q + 2'd1;
		end
		if (cmd.load) begin
			ratio_q <= ratio_calc;
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= CNT_W'(DIV_STEPS);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q <= NUM_W'(cred_q) + NUM_W'(d_sel) - NUM_W'(1);
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= trial_ge ? DURATION_BITS'(trial - {1'b0, d_sel}) : trial[DURATION_BITS-1:0];
			quo_q <= {quo_q[NUM_W-2:0], trial_ge};
		end
	end

	// status
	assign stat.prv       = prv_q;
	assign stat.en        = en_q;
	assign stat.k_done    = (k_q == 2'd3);
	assign stat.pos_ge_hi = (pos_q >= hi);
	assign stat.len_zero  = (d_sel == '0);
	assign stat.div_last  = (cnt_q == CNT_W'(1));
	assign stat.sum_le_hi = (sum <= hi);

	assign ratio = ratio_q;

endmodule

@@ rtl/tpdre_ctrl.sv @@
// Controller state machine: sequences segment checks, divide, add and
// multiply steps, and owns the input ready and output valid. Depends on tpdre_pkg.
module tpdre_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  tpdre_pkg::stat_t stat,
	output tpdre_pkg::cmd_t  cmd
);
	import tpdre_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_DIV   = 6'b000100,
		S_ADD   = 6'b001000,
		S_MUL   = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.init = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (!stat.prv || stat.k_done) begin
					state_d = S_FIN;
				end else if (stat.pos_ge_hi) begin
					cmd.adv = 1'b1;
				end else if (stat.len_zero) begin
					cmd.skip = 1'b1;
				end else if (!stat.en) begin
					cmd.clamp = 1'b1;
					state_d   = S_FIN;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = stat.sum_le_hi ? S_FIN : S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CHECK;
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// a waiting result is never dropped before it is taken
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q)
		else $error("result beat dropped while stalled");

	// the result register is only written when the slot is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> slot_free)
		else $error("result overwritten before it was taken");

	// the add step only follows the last divide step
	a_add_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD) |-> $past(state_q == S_DIV && stat.div_last))
		else $error("add step without a finished divide");

	// no new item is taken while one is in work
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while another is in work");

endmodule

@@ rtl/three_phase_delay_ramp_envelope_top.sv @@
// Sequence: with preview off the result is registered straight after the check; a timed
// beat runs one check per segment and, per stepped segment, the restoring divider, add and
// multiply (no multiply where the step ends inside the segment).
// Throughput: one item at a time; the next beat is taken once the result is registered.
// Reset: arst_n asynchronous active low clears lengths, position, state and output valid.
// Instantiates tpdre_cfg, tpdre_ctrl and tpdre_dp; depends on tpdre_pkg.
module three_phase_delay_ramp_envelope_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// bit 0 reverse, bit 1 preview, bit 2 enabled, rest zero
	input  logic [tpdre_pkg::IN_W-1:0]    s_tdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// bits 16:0 ratio, rest zero
	output logic [tpdre_pkg::OUT_W-1:0]   m_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpdre_pkg::ADDR_W-1:0]  paddr,
	input  logic [tpdre_pkg::DATA_W-1:0]  pwdata,
	output logic [tpdre_pkg::DATA_W-1:0]  prdata,
	output logic                          pready
);
	import tpdre_pkg::*;

	lens_t              lens;
	cmd_t               cmd;
	stat_t              stat;
	logic [RATIO_W-1:0] ratio;

	assign pready  = 1'b1;
	assign m_tdata = OUT_W'(ratio);

	tpdre_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.lens    (lens)
	);

	tpdre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tpdre_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (s_tdata),
		.lens    (lens),
		.cmd     (cmd),
		.stat    (stat),
		.ratio   (ratio)
	);

endmodule
